[hw/rtl/gass_pkg.sv]
// Package with shared types and constants for the global alignment score block.
package gass_pkg;

    localparam int NUM_REGS = 5;
    localparam int REG_WIDTH = 60;
    localparam int REG_IDX_WIDTH = 3;
    localparam int FIELD_WIDTH = 12;
    localparam int SCORE_WIDTH = 32;
    localparam int TOTAL_WIDTH = 48;

    localparam logic [2:0] GAP_SYM = 3'd4;

    typedef enum logic [1:0] {
        CMD_CONS  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EMPTY = 2'd2,
        CMD_CLEAR = 2'd3
    } command_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] base;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic signed [SCORE_WIDTH-1:0] read_score;
        logic signed [TOTAL_WIDTH-1:0] total_score;
        logic                          length_error;
    } out_word_t;

    function automatic logic signed [FIELD_WIDTH-1:0] pick_score(
        input logic [REG_WIDTH-1:0] row,
        input logic [2:0]           sym
    );
        logic [REG_WIDTH-1:0] shifted;
        begin
            shifted = row >> (FIELD_WIDTH * int'(sym));
            return shifted[FIELD_WIDTH-1:0];
        end
    endfunction

endpackage

[hw/rtl/gass_stream_if.sv]
// Valid-ready channel interface carrying one word.
interface gass_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/gass_cell_unit.sv]
// Shared cell: three saturating adds and a three-way max, or the up sum.
module gass_cell_unit #(
    parameter int CELL_WIDTH = 32
) (
    input  logic signed [CELL_WIDTH-1:0]       old_cell,
    input  logic signed [CELL_WIDTH-1:0]       prev_cell,
    input  logic signed [CELL_WIDTH-1:0]       diag_cell,
    input  logic signed [gass_pkg::FIELD_WIDTH-1:0] left_gap,
    input  logic signed [gass_pkg::FIELD_WIDTH-1:0] up_gap,
    input  logic signed [gass_pkg::FIELD_WIDTH-1:0] diag_score,
    input  logic                               full_cell,
    output logic signed [CELL_WIDTH-1:0]       new_cell
);
    import gass_pkg::*;

    function automatic logic signed [CELL_WIDTH-1:0] sat_add(
        input logic signed [CELL_WIDTH-1:0]  a,
        input logic signed [FIELD_WIDTH-1:0] b
    );
        logic signed [CELL_WIDTH:0] s;
        begin
            s = {a[CELL_WIDTH-1], a} + (CELL_WIDTH+1)'(b);
            if (s[CELL_WIDTH] != s[CELL_WIDTH-1])
                return s[CELL_WIDTH] ? {1'b1, {(CELL_WIDTH-1){1'b0}}}
                                     : {1'b0, {(CELL_WIDTH-1){1'b1}}};
            return s[CELL_WIDTH-1:0];
        end
    endfunction

    logic signed [CELL_WIDTH-1:0] left_v;
    logic signed [CELL_WIDTH-1:0] up_v;
    logic signed [CELL_WIDTH-1:0] diag_v;
    logic signed [CELL_WIDTH-1:0] m1;

    always_comb
    begin
        left_v = sat_add(old_cell, left_gap);
        up_v = sat_add(prev_cell, up_gap);
        diag_v = sat_add(diag_cell, diag_score);
        m1 = (left_v > up_v) ? left_v : up_v;
        if (!full_cell)
            new_cell = up_v;
        else
            new_cell = (m1 > diag_v) ? m1 : diag_v;
    end
endmodule

[hw/rtl/global_alignment_score_sum.sv]
// Top level of the global alignment score block with running total.
//
// Channel   Direction  Word
// in_ch     sink       command, base, last
// out_ch    source     read_score, total_score, length_error
//
// A word is accepted only in the idle state. Each DP cell takes a memory read phase, then
// a compute and write phase, on the shared cell unit; the first base of a read adds an
// initialization pass over the consensus column. An empty read takes one initialization
// pass; a finished read adds a result read and output step. Consensus and clear words
// are handled in the idle state. Reset leaves memories undefined.
// A result waits in the output register while the next word is accepted; a later result
// stalls until that register is free.
module global_alignment_score_sum #(
    parameter int MAX_CONSENSUS = 4096,
    parameter int CELL_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [gass_pkg::REG_IDX_WIDTH-1:0] cfg_index,
    input  logic [gass_pkg::REG_WIDTH-1:0] cfg_data,
    gass_stream_if.sink   in_ch,
    gass_stream_if.source out_ch
);
    import gass_pkg::*;

    localparam int AW = $clog2(MAX_CONSENSUS + 1);
    localparam int LW = $clog2(MAX_CONSENSUS + 1);
    localparam int SW = (MAX_CONSENSUS > 1) ? $clog2(MAX_CONSENSUS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_INIT  = 4'b0010,
        ST_UPD   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    logic [REG_WIDTH-1:0] regs_reg [NUM_REGS];
    logic [1:0]  cons_mem [MAX_CONSENSUS];
    logic signed [CELL_WIDTH-1:0] col_mem [MAX_CONSENSUS+1];

    state_t state_reg, state_next;
    logic [LW-1:0] len_reg;
    logic complete_reg, overflow_reg, in_read_reg;
    logic signed [TOTAL_WIDTH-1:0] total_reg;
    logic [AW-1:0] idx_reg;
    logic [1:0] base_reg;
    logic last_reg, upd_after_reg;
    logic signed [CELL_WIDTH-1:0] prev_reg, diag_reg;
    logic out_valid_reg;
    out_word_t out_reg;

    logic signed [CELL_WIDTH-1:0] rd_cell;
    logic [1:0] rd_cons;
    logic rd_phase_reg;
    logic signed [CELL_WIDTH-1:0] new_cell;
    logic signed [FIELD_WIDTH-1:0] left_gap, up_gap, diag_score;
    logic [2:0] cons_row;
    logic in_acc;
    logic out_free;
    logic emit;
    logic signed [64:0] cell_wide;
    logic signed [SCORE_WIDTH-1:0] sat_score;
    logic signed [TOTAL_WIDTH:0] tsum;
    logic signed [TOTAL_WIDTH-1:0] total_next;

    assign in_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit = (state_reg == ST_DONE) && rd_phase_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= '0;
        end
        else if (cfg_we && (int'(cfg_index) < NUM_REGS))
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // Each cell takes a read phase then a compute/write phase.
    assign cons_row = {1'b0, rd_cons};
    assign left_gap = pick_score(regs_reg[GAP_SYM], {1'b0, base_reg});
    assign up_gap = pick_score(regs_reg[cons_row], GAP_SYM);
    assign diag_score = pick_score(regs_reg[cons_row], {1'b0, base_reg});

    gass_cell_unit #(.CELL_WIDTH(CELL_WIDTH)) u_cell (
        .old_cell  (rd_cell),
        .prev_cell ((idx_reg == '0) ? rd_cell : prev_reg),
        .diag_cell (diag_reg),
        .left_gap  (left_gap),
        .up_gap    ((idx_reg == '0) ? left_gap : up_gap),
        .diag_score(diag_score),
        .full_cell (state_reg == ST_UPD && idx_reg != '0),
        .new_cell  (new_cell)
    );

    logic signed [CELL_WIDTH-1:0] init_cell;
    always_comb
    begin
        if (idx_reg == '0)
            init_cell = '0;
        else
            init_cell = new_cell;
    end

    always_ff @(posedge clk)
    begin
        rd_cell <= col_mem[idx_reg];
        rd_cons <= cons_mem[SW'(idx_reg - AW'(1))];
        if (in_acc && in_ch.data.command == CMD_CONS && !in_read_reg)
        begin
            if (complete_reg)
                cons_mem[0] <= in_ch.data.base;
            else if (int'(len_reg) < MAX_CONSENSUS)
                cons_mem[SW'(len_reg)] <= in_ch.data.base;
        end
        if (rd_phase_reg && state_reg == ST_INIT)
            col_mem[idx_reg] <= init_cell;
        if (rd_phase_reg && state_reg == ST_UPD)
            col_mem[idx_reg] <= (idx_reg == '0) ? new_cell : new_cell;
    end

    always_comb
    begin
        cell_wide = 65'(rd_cell);
        if (cell_wide > 65'sh0_7FFF_FFFF)
            sat_score = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
        else if (cell_wide < -65'sh0_8000_0000)
            sat_score = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
        else
            sat_score = cell_wide[SCORE_WIDTH-1:0];
        tsum = {total_reg[TOTAL_WIDTH-1], total_reg} + (TOTAL_WIDTH+1)'(sat_score);
        if (tsum[TOTAL_WIDTH] != tsum[TOTAL_WIDTH-1])
            total_next = tsum[TOTAL_WIDTH] ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}}
                                           : {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
        else
            total_next = tsum[TOTAL_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.data.command == CMD_READ)
                    state_next = in_read_reg ? ST_UPD : ST_INIT;
                else if (in_acc && in_ch.data.command == CMD_EMPTY)
                    state_next = ST_INIT;
            end
            ST_INIT:
                if (rd_phase_reg && idx_reg == AW'(len_reg))
                    state_next = upd_after_reg ? ST_UPD : ST_DONE;
            ST_UPD:
                if (rd_phase_reg && idx_reg == AW'(len_reg))
                    state_next = last_reg ? ST_DONE : ST_IDLE;
            ST_DONE:
                if (emit)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg <= '0;
            complete_reg <= 1'b0;
            overflow_reg <= 1'b0;
            in_read_reg <= 1'b0;
            total_reg <= '0;
            idx_reg <= '0;
            rd_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            upd_after_reg <= 1'b0;
            last_reg <= 1'b0;
            base_reg <= '0;
            prev_reg <= '0;
            diag_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    rd_phase_reg <= 1'b0;
                    if (in_acc)
                    begin
                        base_reg <= in_ch.data.base;
                        last_reg <= in_ch.data.last;
                        unique case (command_t'(in_ch.data.command))
                            CMD_CONS:
                                if (!in_read_reg)
                                begin
                                    if (complete_reg)
                                    begin
                                        len_reg <= LW'(1);
                                        overflow_reg <= 1'b0;
                                        complete_reg <= in_ch.data.last;
                                    end
                                    else
                                    begin
                                        if (int'(len_reg) < MAX_CONSENSUS)
                                            len_reg <= len_reg + LW'(1);
                                        else
                                            overflow_reg <= 1'b1;
                                        if (in_ch.data.last)
                                            complete_reg <= 1'b1;
                                    end
                                end
                            CMD_READ:
                            begin
                                upd_after_reg <= 1'b1;
                                in_read_reg <= 1'b1;
                            end
                            CMD_EMPTY:
                            begin
                                upd_after_reg <= 1'b0;
                                in_read_reg <= 1'b0;
                            end
                            CMD_CLEAR:
                            begin
                                len_reg <= '0;
                                complete_reg <= 1'b0;
                                overflow_reg <= 1'b0;
                                in_read_reg <= 1'b0;
                                total_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_INIT, ST_UPD:
                begin
                    rd_phase_reg <= !rd_phase_reg;
                    if (rd_phase_reg)
                    begin
                        prev_reg <= (state_reg == ST_INIT) ? init_cell : new_cell;
                        diag_reg <= rd_cell;
                        if (idx_reg == AW'(len_reg))
                            idx_reg <= (state_next == ST_DONE) ? idx_reg : '0;
                        else
                            idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!rd_phase_reg)
                        rd_phase_reg <= 1'b1;
                    else if (out_free)
                    begin
                        rd_phase_reg <= 1'b0;
                        idx_reg <= '0;
                        total_reg <= total_next;
                        in_read_reg <= 1'b0;
                        out_reg.read_score <= sat_score;
                        out_reg.total_score <= total_next;
                        out_reg.length_error <= overflow_reg || !complete_reg;
                    end
                end
                default: ;
            endcase
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(len_reg) <= MAX_CONSENSUS)
        else $error("consensus length overflow");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result not presented");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= AW'(len_reg))
        else $error("cell index out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result changed while stalled");
endmodule

[bench/tb_global_alignment_score_sum.sv]
// Testbench for the global alignment score block: stimulus, scoreboard and checks.
`timescale 1ns / 1ps

module tb_global_alignment_score_sum;
    import gass_pkg::*;

    class score_board;
        localparam int MAX_CONS = 4096;
        localparam longint CELL_HI = 64'sd2147483647;
        localparam longint SCORE_HI = 64'sd2147483647;
        localparam longint TOTAL_HI = 64'sd140737488355327;

        logic [REG_WIDTH-1:0] score_rows [NUM_REGS];
        logic [1:0] cons_bases [MAX_CONS];
        longint column [MAX_CONS + 1];
        int unsigned cons_len;
        bit read_open;
        bit cons_done;
        bit cons_overflow;
        longint diag_cell;
        longint total_sum;
        out_word_t pending [$];
        int errors;

        function new();
            foreach (score_rows[i])
                score_rows[i] = '0;
            clear_state();
            errors = 0;
        endfunction

        function longint sub_score(int row, int sym);
            logic signed [FIELD_WIDTH-1:0] f;
            f = score_rows[row][FIELD_WIDTH * sym +: FIELD_WIDTH];
            return longint'(f);
        endfunction

        function longint sat_add(longint a, longint b, longint hi);
            longint lo;
            lo = -hi - 1;
            if (b > 0 && a > hi - b)
                return hi;
            if (b < 0 && a < lo - b)
                return lo;
            return a + b;
        endfunction

        function void clear_state();
            cons_len = 0;
            read_open = 0;
            cons_done = 0;
            cons_overflow = 0;
            diag_cell = 0;
            total_sum = 0;
        endfunction

        function void init_column();
            column[0] = 0;
            for (int i = 1; i <= cons_len; i++)
                column[i] = sat_add(column[i-1], sub_score(cons_bases[i-1], GAP_SYM),
                                    CELL_HI);
        endfunction

        function void update_column(int b);
            longint left_gap;
            longint prev;
            longint left;
            longint up;
            longint diag;
            longint best;
            left_gap = sub_score(GAP_SYM, b);
            diag_cell = column[0];
            column[0] = sat_add(column[0], left_gap, CELL_HI);
            for (int i = 1; i <= cons_len; i++) begin
                prev = column[i];
                left = sat_add(prev, left_gap, CELL_HI);
                up = sat_add(column[i-1], sub_score(cons_bases[i-1], GAP_SYM), CELL_HI);
                diag = sat_add(diag_cell, sub_score(cons_bases[i-1], b), CELL_HI);
                best = left > up ? left : up;
                column[i] = best > diag ? best : diag;
                diag_cell = prev;
            end
        endfunction

        function void finish_read();
            longint s;
            out_word_t r;
            s = column[cons_len];
            if (s > SCORE_HI)
                s = SCORE_HI;
            if (s < -SCORE_HI - 1)
                s = -SCORE_HI - 1;
            total_sum = sat_add(total_sum, s, TOTAL_HI);
            read_open = 0;
            r.read_score = s[SCORE_WIDTH-1:0];
            r.total_score = total_sum[TOTAL_WIDTH-1:0];
            r.length_error = cons_overflow || !cons_done;
            pending.push_back(r);
        endfunction

        function void note_input(in_word_t w);
            case (command_t'(w.command))
                CMD_CONS:
                begin
                    if (!read_open) begin
                        if (cons_done) begin
                            cons_len = 0;
                            cons_done = 0;
                            cons_overflow = 0;
                        end
                        if (cons_len < MAX_CONS) begin
                            cons_bases[cons_len] = w.base;
                            cons_len++;
                        end
                        else
                            cons_overflow = 1;
                        if (w.last)
                            cons_done = 1;
                    end
                end
                CMD_READ:
                begin
                    if (!read_open) begin
                        init_column();
                        read_open = 1;
                    end
                    update_column(w.base);
                    if (w.last)
                        finish_read();
                end
                CMD_EMPTY:
                begin
                    init_column();
                    finish_read();
                end
                default:
                    clear_state();
            endcase
        endfunction

        function void check_result(out_word_t r);
            out_word_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.read_score !== e.read_score) begin
                $display("%0t: read_score expected %0d actual %0d", $time, e.read_score,
                         r.read_score);
                errors++;
            end
            if (r.total_score !== e.total_score) begin
                $display("%0t: total_score expected %0d actual %0d", $time, e.total_score,
                         r.total_score);
                errors++;
            end
            if (r.length_error !== e.length_error) begin
                $display("%0t: length_error expected %0b actual %0b", $time, e.length_error,
                         r.length_error);
                errors++;
            end
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 9000;
    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_WIDTH-1:0] cfg_index;
    logic [REG_WIDTH-1:0] cfg_data;
    int src_idle;
    int sink_stall;
    int sent;
    int quiet_cycles;
    score_board board;

    gass_stream_if #(.word_t(in_word_t)) in_ch ();
    gass_stream_if #(.word_t(out_word_t)) out_ch ();

    global_alignment_score_sum dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall);
        if (out_ch.valid && out_ch.ready)
            board.check_result(out_ch.data);
        if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("global_alignment_score_sum: mismatch");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [1:0] b, input logic lst);
        in_word_t w;
        w.command = cmd;
        w.base = b;
        w.last = lst;
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_input(w);
        sent++;
    endtask

    task automatic send_consensus(input int len);
        for (int i = 0; i < len; i++)
            send_word(CMD_CONS, 2'($urandom_range(3)), i == len - 1);
    endtask

    task automatic send_read(input int len);
        for (int i = 0; i < len; i++)
            send_word(CMD_READ, 2'($urandom_range(3)), i == len - 1);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rows(input int mode);
        logic [REG_WIDTH-1:0] row;
        wait_idle();
        for (int r = 0; r < NUM_REGS; r++) begin
            case (mode)
                0: row = {12'hFFE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
                1: row = {5{12'h7FF}};
                2: row = {5{12'h800}};
                3: row = '0;
                default: row = REG_WIDTH'({$urandom, $urandom});
            endcase
            if (mode == 0) begin
                if (r < 4)
                    row[FIELD_WIDTH * r +: FIELD_WIDTH] = 12'd2;
                else
                    row = {12'd0, {4{12'hFFE}}};
            end
            cfg_we <= 1'b1;
            cfg_index <= REG_IDX_WIDTH'(r);
            cfg_data <= row;
            @(posedge clk);
            board.score_rows[r] = row;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_block(input int count);
        int stop;
        int r;
        stop = sent + count;
        while (sent < stop) begin
            r = $urandom_range(99);
            if (r < 60) begin
                send_consensus($urandom_range(1, 10));
                repeat ($urandom_range(1, 3)) send_read($urandom_range(1, 6));
            end
            else if (r < 70)
                send_word(CMD_EMPTY, 2'($urandom_range(3)), 1'($urandom_range(1)));
            else if (r < 75)
                send_word(CMD_CLEAR, 2'($urandom_range(3)), 1'($urandom_range(1)));
            else if (r < 85) begin
                send_word(CMD_READ, 2'($urandom_range(3)), 1'b0);
                send_word(CMD_CONS, 2'($urandom_range(3)), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    send_word(CMD_EMPTY, 2'($urandom_range(3)), 1'($urandom_range(1)));
                else
                    send_read($urandom_range(1, 3));
            end
            else
                send_word(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        src_idle = 0;
        sink_stall = 0;
        sent = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_rows(0);
        send_word(CMD_READ, 2'd0, 1'b1);
        send_word(CMD_EMPTY, 2'd3, 1'b0);
        send_word(CMD_CONS, 2'd0, 1'b0);
        send_word(CMD_CONS, 2'd1, 1'b0);
        send_word(CMD_READ, 2'd1, 1'b1);
        send_word(CMD_CONS, 2'd2, 1'b0);
        send_word(CMD_CONS, 2'd3, 1'b1);
        send_word(CMD_READ, 2'd0, 1'b0);
        send_word(CMD_READ, 2'd1, 1'b0);
        send_word(CMD_CONS, 2'd3, 1'b1);
        send_word(CMD_READ, 2'd2, 1'b0);
        send_word(CMD_READ, 2'd3, 1'b1);
        send_word(CMD_EMPTY, 2'd0, 1'b1);
        send_word(CMD_READ, 2'd3, 1'b0);
        send_word(CMD_EMPTY, 2'd1, 1'b0);
        send_word(CMD_CONS, 2'd3, 1'b1);
        send_word(CMD_READ, 2'd3, 1'b1);
        send_word(CMD_CLEAR, 2'd2, 1'b1);
        send_word(CMD_READ, 2'd2, 1'b1);
        send_word(CMD_CONS, 2'd1, 1'b1);
        send_word(CMD_READ, 2'd1, 1'b1);

        for (int p = 0; p < 6; p++) begin
            write_rows(p == 0 ? 0 : (p < 4 ? p : 4));
            src_idle = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 1 ? 72 : 24) : 0;
            sink_stall = (p % 4 == 2 || p % 4 == 3) ? (p % 4 == 2 ? 72 : 24) : 0;
            random_block(20);
        end

        wait_idle();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("global_alignment_score_sum: match");
        else
            $display("global_alignment_score_sum: mismatch");
        $finish;
    end
endmodule
